[src/obj_fpt_pkg.sv]
// ----------------------------------------------------------------------------
// obj_fpt_pkg
// Shared types and constants for the face-line parser with fan triangulation.
// ----------------------------------------------------------------------------
package obj_fpt_pkg;

    // Largest number of corners accepted in one face.
    localparam int MAX_CORNERS = 16;
    // Corner counter width: it must hold MAX_CORNERS itself.
    localparam int CNT_W = $clog2(MAX_CORNERS + 1);

    localparam int IDX_W  = 32;
    localparam int CNUM_W = 4;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Which field of a corner is being parsed.
    typedef enum logic [1:0] {
        PH_POS,
        PH_TEX,
        PH_NRM
    } t_phase;

    // Byte classes seen by the parser.
    typedef enum logic [2:0] {
        BK_DIGIT,
        BK_SLASH,
        BK_SPACE,
        BK_END,
        BK_OTHER
    } t_byte_kind;

    typedef struct packed {
        t_byte_kind kind;
        logic [3:0] digit;
    } t_byte_class;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic              corner_valid;
        logic [IDX_W-1:0]  pos_index;
        logic [IDX_W-1:0]  uv_index;
        logic [IDX_W-1:0]  normal_index;
        logic              uv_present;
        logic              normal_present;
        logic [CNUM_W-1:0] corner_number;
        logic              tri_valid;
        logic [IDX_W-1:0]  tri_first;
        logic [IDX_W-1:0]  tri_second;
        logic [IDX_W-1:0]  tri_third;
        logic              face_end;
    } t_result;

endpackage

[src/obj_face_parse_fan_triangulate.sv]
// ----------------------------------------------------------------------------
// obj_face_parse_fan_triangulate
// Face-line parser with fan triangulation of its corners.
// ----------------------------------------------------------------------------
// Usage: send the bytes of one face line, after its tag, on the input channel
// (i_in_valid / o_in_ready / i_in_byte). A newline or zero byte ends the face.
// Each corner closed under the limit gives one output request with its indices
// minus one, presence flags and, from the third corner on, the fan triangle.
// Each line end gives one request with o_face_end set; when no corner closes
// there, o_pos_index carries the corner count and o_uv_index the overflow.
// Digits, slashes and bytes that close nothing give no output request.
// A taken byte waits in the input register, and its result in the result
// register. Throughput: one byte per cycle unless the receiver stalls. The
// cycle is set by the parse step: the multiply-by-ten-and-add on the 32-bit
// accumulator and the triangle adders.
// Reset (synchronous, active low) clears the parse state, the corner count
// and the base vertex counter, and empties both register stages.
// A stalled receiver holds the result register; one more byte can wait in
// the input register, and then o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module obj_face_parse_fan_triangulate
    import obj_fpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_corner_valid,
    output logic [IDX_W-1:0]  o_pos_index,
    output logic [IDX_W-1:0]  o_uv_index,
    output logic [IDX_W-1:0]  o_normal_index,
    output logic              o_uv_present,
    output logic              o_normal_present,
    output logic [CNUM_W-1:0] o_corner_number,
    output logic              o_tri_valid,
    output logic [IDX_W-1:0]  o_tri_first,
    output logic [IDX_W-1:0]  o_tri_second,
    output logic [IDX_W-1:0]  o_tri_third,
    output logic              o_face_end
);

    logic        s_in_valid;
    t_byte_class s_class;
    logic        s_free;
    logic        s_step;
    logic        s_has_result;
    t_result     s_result;
    t_result     s_out;

    // A held byte is parsed whenever the result register can take its result.
    assign s_step = s_in_valid && s_free;

    obj_fpt_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_step     (s_step),
        .o_valid    (s_in_valid),
        .o_class    (s_class)
    );

    obj_fpt_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s_step),
        .i_class      (s_class),
        .o_has_result (s_has_result),
        .o_result     (s_result)
    );

    obj_fpt_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s_step),
        .i_has_result (s_has_result),
        .i_result     (s_result),
        .o_free       (s_free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (s_out)
    );

    assign o_corner_valid   = s_out.corner_valid;
    assign o_pos_index      = s_out.pos_index;
    assign o_uv_index       = s_out.uv_index;
    assign o_normal_index   = s_out.normal_index;
    assign o_uv_present     = s_out.uv_present;
    assign o_normal_present = s_out.normal_present;
    assign o_corner_number  = s_out.corner_number;
    assign o_tri_valid      = s_out.tri_valid;
    assign o_tri_first      = s_out.tri_first;
    assign o_tri_second     = s_out.tri_second;
    assign o_tri_third      = s_out.tri_third;
    assign o_face_end       = s_out.face_end;

endmodule

[src/obj_fpt_in_reg.sv]
// ----------------------------------------------------------------------------
// obj_fpt_in_reg
// Input register stage: takes one byte per request and stores its class.
// ----------------------------------------------------------------------------
module obj_fpt_in_reg
    import obj_fpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_step,
    output logic        o_valid,
    output t_byte_class o_class
);

    logic        r_valid;
    t_byte_class r_class;
    t_byte_class n_class;
    logic [3:0]  s_digit_off;

    // The stage frees up whenever the held byte moves on to the parser.
    assign o_in_ready = !r_valid || i_step;

    // Classify the incoming byte.
    assign s_digit_off = i_in_byte[3:0] - CH_ZERO[3:0];
    always_comb begin
        n_class.digit = s_digit_off;
        if (i_in_byte >= CH_ZERO && i_in_byte <= CH_NINE) begin
            n_class.kind = BK_DIGIT;
        end else if (i_in_byte == CH_SLASH) begin
            n_class.kind = BK_SLASH;
        end else if (i_in_byte == CH_SPACE || i_in_byte == CH_TAB || i_in_byte == CH_CR) begin
            n_class.kind = BK_SPACE;
        end else if (i_in_byte == CH_NL || i_in_byte == CH_NUL) begin
            n_class.kind = BK_END;
        end else begin
            n_class.kind = BK_OTHER;
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Class register.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_class <= n_class;
        end
    end

    assign o_valid = r_valid;
    assign o_class = r_class;

endmodule

[src/obj_fpt_parse.sv]
// ----------------------------------------------------------------------------
// obj_fpt_parse
// Corner parser state and fan triangulation, one byte per step.
// ----------------------------------------------------------------------------
module obj_fpt_parse
    import obj_fpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_byte_class i_class,
    output logic        o_has_result,
    output t_result     o_result
);

    t_phase           r_phase,    n_phase;
    logic [IDX_W-1:0] r_accum,    n_accum;
    logic [IDX_W-1:0] r_held_pos, n_held_pos;
    logic [IDX_W-1:0] r_held_tex, n_held_tex;
    logic [1:0]       r_flags,    n_flags;
    logic             r_digits,   n_digits;
    logic [CNT_W-1:0] r_count,    n_count;
    logic [IDX_W-1:0] r_base,     n_base;
    logic             r_overflow, n_overflow;

    logic [IDX_W-1:0] s_accum_m1;
    logic [IDX_W-1:0] s_k_ext;
    logic             s_open;
    logic             s_full;
    logic             s_take;
    logic             s_uv_new;
    logic             s_nrm_new;
    logic             s_uv_p;
    logic             s_nrm_p;
    logic [IDX_W-1:0] s_uv;
    logic [CNT_W-1:0] s_count_after;
    t_result          s_corner;

    // What closing the open corner would give.
    assign s_accum_m1 = r_accum - 1'b1;
    assign s_k_ext    = IDX_W'(r_count);
    assign s_open     = (r_phase != PH_POS) || r_digits;
    assign s_full     = r_count >= CNT_W'(MAX_CORNERS);
    assign s_take     = s_open && !s_full;
    assign s_uv_new   = (r_phase == PH_TEX) && r_digits;
    assign s_nrm_new  = (r_phase == PH_NRM) && r_digits;
    assign s_uv_p     = r_flags[0] || s_uv_new;
    assign s_nrm_p    = r_flags[1] || s_nrm_new;
    assign s_uv       = s_uv_new ? s_accum_m1 : r_held_tex;
    assign s_count_after = r_count + CNT_W'(s_take);

    always_comb begin
        s_corner                = '0;
        s_corner.corner_valid   = 1'b1;
        s_corner.pos_index      = (r_phase == PH_POS) ? s_accum_m1 : r_held_pos;
        s_corner.uv_index       = s_uv_p ? s_uv : '0;
        s_corner.normal_index   = s_nrm_new ? s_accum_m1 : '0;
        s_corner.uv_present     = s_uv_p;
        s_corner.normal_present = s_nrm_p;
        s_corner.corner_number  = s_k_ext[CNUM_W-1:0];
        // From the third corner on, emit the fan triangle.
        if (r_count >= CNT_W'(2)) begin
            s_corner.tri_valid  = 1'b1;
            s_corner.tri_first  = r_base;
            s_corner.tri_second = r_base + (s_k_ext - 1'b1);
            s_corner.tri_third  = r_base + s_k_ext;
        end
    end

    // Next state and result.
    always_comb begin
        n_phase      = r_phase;
        n_accum      = r_accum;
        n_held_pos   = r_held_pos;
        n_held_tex   = r_held_tex;
        n_flags      = r_flags;
        n_digits     = r_digits;
        n_count      = r_count;
        n_base       = r_base;
        n_overflow   = r_overflow;
        o_has_result = 1'b0;
        o_result     = '0;
        case (i_class.kind)
            BK_DIGIT: begin
                n_accum  = (r_accum << 3) + (r_accum << 1) + IDX_W'(i_class.digit);
                n_digits = 1'b1;
            end
            BK_SLASH: begin
                if (r_phase == PH_POS) begin
                    n_held_pos = s_accum_m1;
                    n_phase    = PH_TEX;
                    n_accum    = '0;
                    n_digits   = 1'b0;
                end else if (r_phase == PH_TEX) begin
                    if (r_digits) begin
                        n_held_tex = s_accum_m1;
                        n_flags[0] = 1'b1;
                    end
                    n_phase  = PH_NRM;
                    n_accum  = '0;
                    n_digits = 1'b0;
                end
            end
            BK_SPACE: begin
                if (s_open) begin
                    n_phase    = PH_POS;
                    n_accum    = '0;
                    n_held_pos = '0;
                    n_held_tex = '0;
                    n_flags    = '0;
                    n_digits   = 1'b0;
                    if (s_full) begin
                        n_overflow = 1'b1;
                    end else begin
                        n_count      = r_count + 1'b1;
                        o_has_result = 1'b1;
                        o_result     = s_corner;
                    end
                end
            end
            BK_END: begin
                o_has_result = 1'b1;
                if (s_take) begin
                    o_result = s_corner;
                end else begin
                    // No corner closes here: report count and overflow.
                    o_result.pos_index = IDX_W'(r_count);
                    o_result.uv_index  = IDX_W'(r_overflow || (s_open && s_full));
                end
                o_result.face_end = 1'b1;
                n_base     = r_base + IDX_W'(s_count_after);
                n_count    = '0;
                n_overflow = 1'b0;
                n_phase    = PH_POS;
                n_accum    = '0;
                n_held_pos = '0;
                n_held_tex = '0;
                n_flags    = '0;
                n_digits   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_POS;
            r_accum    <= '0;
            r_held_pos <= '0;
            r_held_tex <= '0;
            r_flags    <= '0;
            r_digits   <= 1'b0;
            r_count    <= '0;
            r_base     <= '0;
            r_overflow <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_accum    <= n_accum;
            r_held_pos <= n_held_pos;
            r_held_tex <= n_held_tex;
            r_flags    <= n_flags;
            r_digits   <= n_digits;
            r_count    <= n_count;
            r_base     <= n_base;
            r_overflow <= n_overflow;
        end
    end

endmodule

[src/obj_fpt_out_reg.sv]
// ----------------------------------------------------------------------------
// obj_fpt_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module obj_fpt_out_reg
    import obj_fpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_has_result,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // The register can load when empty or when its content leaves now.
    assign o_free = !r_valid || i_out_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_step && i_has_result;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_step && i_has_result) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

[src/obj_fpt_checker.sv]
// ----------------------------------------------------------------------------
// obj_fpt_checker
// Port-level checks on the face parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module obj_fpt_checker
    import obj_fpt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_corner_valid,
    input logic [IDX_W-1:0]  o_pos_index,
    input logic [CNUM_W-1:0] o_corner_number,
    input logic              o_tri_valid,
    input logic [IDX_W-1:0]  o_tri_second,
    input logic [IDX_W-1:0]  o_tri_third,
    input logic              o_face_end
);

    // A triangle only comes with a corner, from the third corner on.
    a_tri_needs_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tri_valid |-> o_corner_valid && (o_corner_number >= CNUM_W'(2)))
        else $error("triangle without a third or later corner");

    // The last two triangle vertices are consecutive ids.
    a_tri_consecutive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tri_valid |-> o_tri_third == o_tri_second + 1'b1)
        else $error("fan triangle vertices not consecutive");

    // A request without a corner is always a line end.
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_corner_valid |-> o_face_end)
        else $error("empty request that is not a line end");

    // A stalled request stays valid and keeps its position index.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_index))
        else $error("stalled output request changed");

endmodule

bind obj_face_parse_fan_triangulate obj_fpt_checker u_obj_fpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_corner_valid  (o_corner_valid),
    .o_pos_index     (o_pos_index),
    .o_corner_number (o_corner_number),
    .o_tri_valid     (o_tri_valid),
    .o_tri_second    (o_tri_second),
    .o_tri_third     (o_tri_third),
    .o_face_end      (o_face_end)
);

[tb/tb_obj_face_parse_fan_triangulate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_obj_face_parse_fan_triangulate
// Self-checking bench for the face-line parser with fan triangulation.
// A byte-level predictor mirrors the corner parser, the face corner counter
// and the running base vertex. Each accepted byte is fed to it, and every
// output request is compared field by field with the oldest prediction.
// Stimulus is a short directed line set followed by random face lines,
// mostly well formed with random index forms, plus raw noise lines, under
// changing sender and receiver idle patterns.
// ----------------------------------------------------------------------------

import obj_fpt_pkg::*;

// Predicts the results of the parser and checks the ones it delivers.
class face_corner_board;

    // Parser copy.
    t_phase           field_phase;
    logic [IDX_W-1:0] digit_accum;
    logic [IDX_W-1:0] held_pos;
    logic [IDX_W-1:0] held_tex;
    logic [1:0]       held_flags;
    bit               digits_seen;
    int               corner_count;
    logic [IDX_W-1:0] base_vertex;
    bit               corner_overflow;

    t_result          corner_queue[$];
    int               mismatches;
    int               reported;
    int               results_checked;
    int               faces_seen;
    int               faces_overflowed;

    function new();
        clear_parse();
        corner_count     = 0;
        base_vertex      = '0;
        corner_overflow  = 1'b0;
        mismatches       = 0;
        reported         = 0;
        results_checked  = 0;
        faces_seen       = 0;
        faces_overflowed = 0;
    endfunction

    function void clear_parse();
        field_phase = PH_POS;
        digit_accum = '0;
        held_pos    = '0;
        held_tex    = '0;
        held_flags  = 2'b00;
        digits_seen = 1'b0;
    endfunction

    function bit corner_open();
        return (field_phase != PH_POS) || digits_seen;
    endfunction

    // Closes the open corner; returns 1 when it was accepted into the face.
    function bit close_corner(output t_result r);
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] uv;
        logic [IDX_W-1:0] nrm;
        logic [1:0]       fl;
        int               k;
        pos = held_pos;
        uv  = held_tex;
        nrm = '0;
        fl  = held_flags;
        r   = '0;
        case (field_phase)
            PH_POS: begin
                pos = digit_accum - 1;
            end
            PH_TEX: begin
                if (digits_seen) begin
                    uv    = digit_accum - 1;
                    fl[0] = 1'b1;
                end
            end
            default: begin
                if (digits_seen) begin
                    nrm   = digit_accum - 1;
                    fl[1] = 1'b1;
                end
            end
        endcase
        clear_parse();

        // A corner beyond the face limit is dropped and only flagged.
        if (corner_count >= MAX_CORNERS) begin
            corner_overflow = 1'b1;
            return 1'b0;
        end
        k = corner_count;
        corner_count++;

        r.corner_valid   = 1'b1;
        r.pos_index      = pos;
        r.uv_index       = fl[0] ? uv : '0;
        r.normal_index   = fl[1] ? nrm : '0;
        r.uv_present     = fl[0];
        r.normal_present = fl[1];
        r.corner_number  = CNUM_W'(k);
        if (k >= 2) begin
            r.tri_valid  = 1'b1;
            r.tri_first  = base_vertex;
            r.tri_second = base_vertex + IDX_W'(k) - 1;
            r.tri_third  = base_vertex + IDX_W'(k);
        end
        return 1'b1;
    endfunction

    // Advances the parser copy by one accepted byte.
    function void note_byte(logic [7:0] b);
        t_result r;
        bit      got;
        r   = '0;
        got = 1'b0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            digit_accum = digit_accum * 10 + IDX_W'(b - CH_ZERO);
            digits_seen = 1'b1;
        end else if (b == CH_SLASH) begin
            // A slash in the normal field has no effect.
            if (field_phase != PH_NRM) begin
                if (field_phase == PH_POS) begin
                    held_pos    = digit_accum - 1;
                    field_phase = PH_TEX;
                end else begin
                    if (digits_seen) begin
                        held_tex      = digit_accum - 1;
                        held_flags[0] = 1'b1;
                    end
                    field_phase = PH_NRM;
                end
                digit_accum = '0;
                digits_seen = 1'b0;
            end
        end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
            if (corner_open() && close_corner(r)) begin
                corner_queue.push_back(r);
            end
        end else if (b == CH_NL || b == CH_NUL) begin
            if (corner_open()) begin
                got = close_corner(r);
            end
            // Without a closing corner the end request reports count and overflow.
            if (!got) begin
                r           = '0;
                r.pos_index = IDX_W'(corner_count);
                r.uv_index  = IDX_W'(corner_overflow);
            end
            r.face_end = 1'b1;
            corner_queue.push_back(r);
            faces_seen++;
            if (corner_overflow) begin
                faces_overflowed++;
            end
            base_vertex     = base_vertex + IDX_W'(corner_count);
            corner_count    = 0;
            corner_overflow = 1'b0;
            clear_parse();
        end
    endfunction

    function int pending();
        return corner_queue.size();
    endfunction

    function void field_diff(string name, logic [IDX_W-1:0] e, logic [IDX_W-1:0] a);
        if (a !== e) begin
            mismatches++;
            if (reported < 10) begin
                reported++;
                $display("[%0t] mismatch on result %0d, %s: expected %h, got %h",
                         $realtime, results_checked, name, e, a);
            end
        end
    endfunction

    // Compares one delivered result with the oldest prediction.
    function void check_result(t_result act);
        t_result exp;
        if (corner_queue.size() == 0) begin
            mismatches++;
            if (reported < 10) begin
                reported++;
                $display("[%0t] result with nothing predicted: %h", $realtime, act);
            end
            return;
        end
        exp = corner_queue.pop_front();
        field_diff("corner_valid",   exp.corner_valid,   act.corner_valid);
        field_diff("pos_index",      exp.pos_index,      act.pos_index);
        field_diff("uv_index",       exp.uv_index,       act.uv_index);
        field_diff("normal_index",   exp.normal_index,   act.normal_index);
        field_diff("uv_present",     exp.uv_present,     act.uv_present);
        field_diff("normal_present", exp.normal_present, act.normal_present);
        field_diff("corner_number",  exp.corner_number,  act.corner_number);
        field_diff("tri_valid",      exp.tri_valid,      act.tri_valid);
        field_diff("tri_first",      exp.tri_first,      act.tri_first);
        field_diff("tri_second",     exp.tri_second,     act.tri_second);
        field_diff("tri_third",      exp.tri_third,      act.tri_third);
        field_diff("face_end",       exp.face_end,       act.face_end);
        results_checked++;
    endfunction

endclass

module tb_obj_face_parse_fan_triangulate;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_e;

    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int TARGET_BYTES = 1150;
    localparam int MODE_SPAN    = 150;
    localparam int END_WAIT     = 8;
    localparam int MAX_GAP      = 40;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [7:0]        i_in_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_corner_valid;
    logic [IDX_W-1:0]  o_pos_index;
    logic [IDX_W-1:0]  o_uv_index;
    logic [IDX_W-1:0]  o_normal_index;
    logic              o_uv_present;
    logic              o_normal_present;
    logic [CNUM_W-1:0] o_corner_number;
    logic              o_tri_valid;
    logic [IDX_W-1:0]  o_tri_first;
    logic [IDX_W-1:0]  o_tri_second;
    logic [IDX_W-1:0]  o_tri_third;
    logic              o_face_end;

    face_corner_board board;
    idle_mode_e       idle_mode = IDLE_NONE;
    int               cycle_count = 0;
    int               bytes_sent = 0;
    int               parsed_bytes = 0;

    obj_face_parse_fan_triangulate u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_byte        (i_in_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_corner_valid   (o_corner_valid),
        .o_pos_index      (o_pos_index),
        .o_uv_index       (o_uv_index),
        .o_normal_index   (o_normal_index),
        .o_uv_present     (o_uv_present),
        .o_normal_present (o_normal_present),
        .o_corner_number  (o_corner_number),
        .o_tri_valid      (o_tri_valid),
        .o_tri_first      (o_tri_first),
        .o_tri_second     (o_tri_second),
        .o_tri_third      (o_tri_third),
        .o_face_end       (o_face_end)
    );

    always #5 i_clk = ~i_clk;

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stalls follow the current idle mode.
    always @(negedge i_clk) begin
        if (idle_mode == IDLE_RECV) begin
            i_out_ready <= ($urandom_range(99) >= 74);
        end else if (idle_mode == IDLE_BOTH) begin
            i_out_ready <= ($urandom_range(99) >= 15);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Every output request taken is checked against the prediction.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_corner_valid, o_pos_index, o_uv_index, o_normal_index,
                    o_uv_present, o_normal_present, o_corner_number, o_tri_valid,
                    o_tri_first, o_tri_second, o_tri_third, o_face_end};
            board.check_result(got);
        end
    end

    function automatic bit is_parsed(logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || b == CH_SLASH || b == CH_SPACE ||
               b == CH_TAB || b == CH_CR || b == CH_NL || b == CH_NUL;
    endfunction

    function automatic int send_idle_pct();
        if (idle_mode == IDLE_SEND) begin
            return 74;
        end else if (idle_mode == IDLE_BOTH) begin
            return 15;
        end
        return 0;
    endfunction

    // Holds off new requests until every predicted result has been taken.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Offers one byte after a random gap and waits for its request to be taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct()) begin
            gap++;
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        board.note_byte(b);
        bytes_sent++;
        if (is_parsed(b)) begin
            parsed_bytes++;
            // Rotate the idle pattern, letting the block drain at each switch.
            if (parsed_bytes % MODE_SPAN == 0) begin
                idle_mode = idle_mode_e'((int'(idle_mode) + 1) % 4);
                wait_drained();
            end
        end
    endtask

    task automatic send_digits(input int n);
        repeat (n) begin
            send_byte(CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    // Mostly short numbers, sometimes ten digits so the accumulator wraps.
    function automatic int pick_digit_count();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(2, 1);
        end else if (r < 90) begin
            return 3;
        end
        return 10;
    endfunction

    function automatic logic [7:0] pick_ignored();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_parsed(b)) begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    task automatic send_space();
        int r;
        r = $urandom_range(2);
        send_byte(r == 0 ? CH_SPACE : (r == 1 ? CH_TAB : CH_CR));
    endtask

    task automatic send_separator();
        send_space();
        if ($urandom_range(99) < 20) begin
            send_space();
        end
        if ($urandom_range(99) < 10) begin
            send_byte(pick_ignored());
        end
    endtask

    // One corner in a random form: p, p/t, p//n, p/t/n, p/, /t/n or extra slash.
    task automatic send_corner();
        int form;
        form = $urandom_range(6);
        if (form != 5) begin
            send_digits(pick_digit_count());
        end
        if (form != 0) begin
            send_byte(CH_SLASH);
        end
        if (form == 1 || form == 3 || form == 5 || form == 6) begin
            send_digits(pick_digit_count());
        end
        if (form >= 2 && form != 4) begin
            send_byte(CH_SLASH);
            send_digits(pick_digit_count());
        end
        if (form == 6) begin
            send_byte(CH_SLASH);
            send_digits(pick_digit_count());
        end
    endtask

    task automatic send_face(input int corners);
        if ($urandom_range(99) < 30) begin
            send_separator();
        end
        for (int i = 0; i < corners; i++) begin
            send_corner();
            if (i < corners - 1) begin
                send_separator();
            end
        end
        if ($urandom_range(99) < 40) begin
            send_separator();
        end
        send_byte($urandom_range(99) < 90 ? CH_NL : CH_NUL);
    endtask

    function automatic int pick_corner_count();
        int r;
        r = $urandom_range(99);
        if (r < 5) begin
            return 0;
        end else if (r < 75) begin
            return $urandom_range(6, 1);
        end else if (r < 90) begin
            return $urandom_range(15, 7);
        end
        return $urandom_range(MAX_CORNERS + 4, MAX_CORNERS);
    endfunction

    // Raw bytes over the full range, then a line end.
    task automatic send_noise_line();
        int len;
        len = $urandom_range(12, 1);
        repeat (len) begin
            send_byte(8'($urandom_range(255)));
        end
        send_byte(CH_NL);
    endtask

    initial begin : stimulus
        logic [7:0] directed[$];
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte  = '0;
        i_out_ready = 1'b0;
        board = new();
        repeat (RESET_CYCLES) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: whitespace with nothing open, zero position, corner
        // forms p/t/n, p//n, p/, every separator, empty position, extra slash
        // in the normal field, an ignored byte, a zero-byte end and an empty line.
        directed = {CH_SPACE, CH_ZERO, CH_SLASH, CH_ZERO + 8'd2, CH_SLASH,
                    CH_ZERO + 8'd3, CH_TAB, CH_ZERO + 8'd4, CH_SLASH, CH_SLASH,
                    CH_ZERO + 8'd5, CH_CR, CH_ZERO + 8'd6, CH_SLASH, CH_NL,
                    CH_SLASH, CH_NINE, CH_SLASH, CH_ZERO + 8'd1, CH_SLASH,
                    CH_ZERO + 8'd2, 8'hFF, CH_SPACE, CH_NUL, CH_NL};
        foreach (directed[i]) begin
            send_byte(directed[i]);
        end
        wait_drained();

        // The first random face always runs past the corner limit.
        send_face($urandom_range(MAX_CORNERS + 4, MAX_CORNERS + 1));
        while (parsed_bytes < TARGET_BYTES) begin
            if ($urandom_range(99) < 85) begin
                send_face(pick_corner_count());
            end else begin
                send_noise_line();
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_WAIT) begin
            @(posedge i_clk);
        end

        $display("tb: %0d bytes offered (%0d parsed), %0d results checked",
                 bytes_sent, parsed_bytes, board.results_checked);
        $display("tb: %0d face lines, %0d over the corner limit, %0d mismatches",
                 board.faces_seen, board.faces_overflowed, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
